### sv/glmrs_pkg.sv
// Shared types, widths and helpers of the grid local minimum risk sum unit.
package glmrs_pkg;

    localparam int HEIGHT_W   = 4;
    localparam int CFG_W      = 8;
    localparam int RISK_W     = 18;
    localparam int COUNT_W    = 15;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W  = OUT_TDATA_W - RISK_W - COUNT_W;
    localparam int SLOT_N     = 3;

    localparam logic [RISK_W-1:0]  RISK_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Configuration register indexes
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    typedef logic [HEIGHT_W-1:0] height_t;
    typedef logic [RISK_W-1:0]   risk_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [1:0]          slot_t;
    typedef logic [SLOT_N-1:0][HEIGHT_W-1:0] col_slots_t;

    // Control part of a judging token that walks along the cell chain
    typedef struct packed {
        logic  valid;
        logic  judge_mid;   // middle row is judged (implies it exists above the last row)
        logic  mid_above;   // middle row has a row above it
        logic  judge_last;  // arriving row is the last row of the grid
        logic  grid_end;    // token closes a grid
        slot_t slot;        // slot that holds the arriving row
    } glmrs_tok_t;

    // Data carried by a token from one cell to the next
    typedef struct packed {
        height_t left_up;
        height_t left_mid;
        height_t left_arr;
        risk_t   risk;
        count_t  count;
    } glmrs_carry_t;

    typedef struct packed {
        count_t count;
        risk_t  risk;
    } glmrs_res_t;

    function automatic slot_t slot_prev(slot_t s);
        slot_t r;
        case (s)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            2'd2:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic slot_t slot_next(slot_t s);
        slot_t r;
        case (s)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            2'd2:    r = 2'd0;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic height_t slot_pick(col_slots_t v, slot_t s);
        height_t r;
        case (s)
            2'd0:    r = v[0];
            2'd1:    r = v[1];
            2'd2:    r = v[2];
            default: r = v[0];
        endcase
        return r;
    endfunction

endpackage

### sv/glmrs_cell.sv
// One column cell: three row slots of its column and one stage of the judging chain.
module glmrs_cell #(
    parameter int IDX      = 0,
    parameter int MAX_COLS = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] wr_col,
    input  glmrs_pkg::slot_t                    wr_slot,
    input  glmrs_pkg::height_t                  wr_height,
    input  glmrs_pkg::col_slots_t               right_slots,
    output glmrs_pkg::col_slots_t               slots,
    input  glmrs_pkg::glmrs_tok_t               tok_in,
    input  glmrs_pkg::glmrs_carry_t             carry_in,
    input  logic [$clog2(MAX_COLS+1)-1:0]       cols_in,
    output glmrs_pkg::glmrs_tok_t               tok_out,
    output glmrs_pkg::glmrs_carry_t             carry_out,
    output logic [$clog2(MAX_COLS+1)-1:0]       cols_out
);
    import glmrs_pkg::*;

    localparam int   CCW      = $clog2(MAX_COLS + 1);
    localparam int   COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic HAS_LEFT = (IDX > 0);

    col_slots_t   slots_reg;
    glmrs_tok_t   tok_reg;
    glmrs_carry_t carry_reg;
    glmrs_carry_t carry_next;
    logic [CCW-1:0] cols_reg;

    slot_t   s_mid;
    slot_t   s_up;
    height_t up;
    height_t mid;
    height_t arr;
    height_t r_up;
    height_t r_mid;
    height_t r_arr;
    logic    in_grid;
    logic    has_right;
    logic    mid_blocked;
    logic    last_blocked;
    logic    low_mid;
    logic    low_last;
    logic [HEIGHT_W:0] add_mid;
    logic [HEIGHT_W:0] add_last;

    // Store the arriving height in this column's slot
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_col == COL_W'(IDX)))
        begin
            for (int s = 0; s < SLOT_N; s++)
            begin
                if (wr_slot == slot_t'(s))
                    slots_reg[s] <= wr_height;
            end
        end
    end

    assign slots = slots_reg;

    always_comb
    begin
        s_mid = slot_prev(tok_in.slot);
        s_up  = slot_prev(s_mid);
        arr   = slot_pick(slots_reg, tok_in.slot);
        mid   = slot_pick(slots_reg, s_mid);
        up    = slot_pick(slots_reg, s_up);
        r_arr = slot_pick(right_slots, tok_in.slot);
        r_mid = slot_pick(right_slots, s_mid);
        r_up  = slot_pick(right_slots, s_up);

        in_grid   = (CCW'(IDX) < cols_in);
        has_right = ((CCW + 1)'(IDX) + (CCW + 1)'(1) < (CCW + 1)'(cols_in));

        // Middle row: own row, row above when present, arriving row below
        mid_blocked = (HAS_LEFT && (carry_in.left_mid <= mid))
                    | (has_right && (r_mid <= mid))
                    | (tok_in.mid_above && ((HAS_LEFT && (carry_in.left_up <= mid))
                                            | (up <= mid)
                                            | (has_right && (r_up <= mid))))
                    | (HAS_LEFT && (carry_in.left_arr <= mid))
                    | (arr <= mid)
                    | (has_right && (r_arr <= mid));

        // Last row: own row and the middle row above it when there is one
        last_blocked = (HAS_LEFT && (carry_in.left_arr <= arr))
                     | (has_right && (r_arr <= arr))
                     | (tok_in.judge_mid && ((HAS_LEFT && (carry_in.left_mid <= arr))
                                             | (mid <= arr)
                                             | (has_right && (r_mid <= arr))));

        low_mid  = tok_in.valid && tok_in.judge_mid && in_grid && !mid_blocked;
        low_last = tok_in.valid && tok_in.judge_last && in_grid && !last_blocked;

        add_mid  = low_mid  ? ((HEIGHT_W + 1)'(mid) + (HEIGHT_W + 1)'(1)) : '0;
        add_last = low_last ? ((HEIGHT_W + 1)'(arr) + (HEIGHT_W + 1)'(1)) : '0;

        carry_next.left_up  = up;
        carry_next.left_mid = mid;
        carry_next.left_arr = arr;
        carry_next.risk     = carry_in.risk + RISK_W'(add_mid) + RISK_W'(add_last);
        carry_next.count    = carry_in.count + COUNT_W'(low_mid) + COUNT_W'(low_last);
    end

    // Advance the token one column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_in;
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        cols_reg  <= cols_in;
    end

    assign tok_out   = tok_reg;
    assign carry_out = carry_reg;
    assign cols_out  = cols_reg;

endmodule

### sv/glmrs_result_fifo.sv
// Result queue with a registered read port that doubles as the output register.
module glmrs_result_fifo #(
    parameter int DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  glmrs_pkg::glmrs_res_t push_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output glmrs_pkg::glmrs_res_t out_data
);
    import glmrs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    glmrs_res_t     mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           out_valid_reg;
    glmrs_res_t     out_data_reg;
    logic           fetch;

    assign fetch = (count_reg != '0) && (!out_valid_reg || out_ready);

    always_comb
    begin
        count_next = count_reg + CW'(push) - CW'(fetch);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
        if (fetch)
            out_data_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + AW'(1);
            if (fetch)
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + AW'(1);
            count_reg <= count_next;
            if (fetch)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (32'(count_reg) < DEPTH || fetch))
        else $error("result queue written while full");

endmodule

### sv/grid_local_minimum_risk_sum_unit.sv
// Top level of the grid local minimum risk sum unit: counters, cell chain and result queue.
//
// Usage:
//   Input channel s_*: one height digit per item in raster order (row by row, left to
//   right). Output channel m_*: one item per grid, carrying the risk sum (height plus
//   one over all strict 3x3 local minima) and the number of those minima.
//   Configuration: cfg_we/cfg_index/cfg_data write grid_rows (index 0) and grid_cols
//   (index 1); zero acts as one, values above MAX_ROWS/MAX_COLS act as the maximum.
//   Throughput: one item per cycle while s_tready is high, grids of any size back to back.
//   Judging chain: at each row end a token walks through all MAX_COLS column cells,
//   one cell per cycle, judging the middle row (and the last row on a grid end) and
//   adding up the risk of that row. The result item is pushed into the queue when
//   the token of the last row of a grid leaves the chain.
//   Each cell keeps its column of the last three rows in rotating slots, so a new row
//   streams in behind a token without disturbing what the token still reads.
//   Reset: grid size 1 x 1, row and column counters and sums cleared; row slots hold
//   no defined data until written. No clearing pass is needed.
//   Stall: results queue up in a memory of FIFO_DEPTH entries; s_tready drops only when
//   FIFO_DEPTH grid results are in flight or waiting, so a stalled receiver throttles
//   the input without losing any item.
module grid_local_minimum_risk_sum_unit #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 128
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [glmrs_pkg::IN_TDATA_W-1:0]      s_tdata,   // [3:0] height
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [glmrs_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [17:0] risk_total,
                                                             // [32:18] low_point_count
    input  logic                                  cfg_we,
    input  logic                                  cfg_index,
    input  logic [glmrs_pkg::CFG_W-1:0]           cfg_data
);
    import glmrs_pkg::*;

    localparam int CCW        = $clog2(MAX_COLS + 1);
    localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCW        = $clog2(MAX_ROWS + 1);
    localparam int FIFO_DEPTH = 2 ** $clog2(MAX_COLS + 4);
    localparam int OCW        = $clog2(FIFO_DEPTH + 1);

    logic [CFG_W-1:0] grid_rows_reg;
    logic [CFG_W-1:0] grid_cols_reg;
    logic [CCW-1:0]   cols_used;
    logic [RCW-1:0]   rows_used;

    logic [CCW-1:0]   col_cnt_reg;
    logic [RCW-1:0]   row_cnt_reg;
    slot_t            slot_reg;
    logic [COL_W-1:0] wr_col;
    logic             accept;
    logic             row_end;
    logic             last_row;
    height_t          height;

    glmrs_tok_t       tok_entry_reg;
    logic [CCW-1:0]   cols_entry_reg;

    glmrs_tok_t       tok_chain   [0:MAX_COLS];
    glmrs_carry_t     carry_chain [0:MAX_COLS];
    logic [CCW-1:0]   cols_chain  [0:MAX_COLS];
    col_slots_t       slot_chain  [0:MAX_COLS-1];

    risk_t            acc_risk_reg;
    count_t           acc_count_reg;
    logic [RISK_W:0]  risk_sum;
    logic [COUNT_W:0] count_sum;
    risk_t            risk_sat;
    count_t           count_sat;
    logic             res_push;
    glmrs_res_t       res_data;
    glmrs_res_t       out_res;

    logic [OCW-1:0]   occ_reg;
    logic             grid_in;
    logic             grid_out;

    // Effective grid size
    always_comb
    begin
        if (grid_cols_reg == '0)
            cols_used = CCW'(1);
        else if (32'(grid_cols_reg) > 32'(MAX_COLS))
            cols_used = CCW'(MAX_COLS);
        else
            cols_used = CCW'(grid_cols_reg);

        if (grid_rows_reg == '0)
            rows_used = RCW'(1);
        else if (32'(grid_rows_reg) > 32'(MAX_ROWS))
            rows_used = RCW'(MAX_ROWS);
        else
            rows_used = RCW'(grid_rows_reg);
    end

    assign height   = s_tdata[HEIGHT_W-1:0];
    assign accept   = s_tvalid && s_tready;
    assign row_end  = ((CCW + 1)'(col_cnt_reg) + (CCW + 1)'(1) >= (CCW + 1)'(cols_used));
    assign last_row = ((RCW + 1)'(row_cnt_reg) + (RCW + 1)'(1) >= (RCW + 1)'(rows_used));
    // Past the last column after a shrink: write into the last column
    assign wr_col   = (col_cnt_reg < cols_used) ? col_cnt_reg[COL_W-1:0]
                                                : COL_W'(cols_used - CCW'(1));
    assign grid_in  = accept && row_end && last_row;
    assign grid_out = m_tvalid && m_tready;
    assign s_tready = (32'(occ_reg) < FIFO_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= CFG_W'(1);
            grid_cols_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                REG_GRID_COLS: grid_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Raster position, row slot rotation and token launch at each row end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            slot_reg      <= '0;
            tok_entry_reg <= '0;
        end
        else
        begin
            tok_entry_reg.valid <= accept && row_end && ((row_cnt_reg != '0) || last_row);
            if (accept)
            begin
                if (!row_end)
                    col_cnt_reg <= col_cnt_reg + CCW'(1);
                else
                begin
                    col_cnt_reg <= '0;
                    slot_reg    <= slot_next(slot_reg);
                    row_cnt_reg <= last_row ? '0 : row_cnt_reg + RCW'(1);

                    tok_entry_reg.judge_mid  <= (row_cnt_reg != '0);
                    tok_entry_reg.mid_above  <= (row_cnt_reg > RCW'(1));
                    tok_entry_reg.judge_last <= last_row;
                    tok_entry_reg.grid_end   <= last_row;
                    tok_entry_reg.slot       <= slot_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && row_end)
            cols_entry_reg <= cols_used;
    end

    assign tok_chain[0]   = tok_entry_reg;
    assign carry_chain[0] = '0;
    assign cols_chain[0]  = cols_entry_reg;

    // Column cells, each handing the token and running sum to its right neighbor
    for (genvar k = 0; k < MAX_COLS; k++)
    begin : g_cell
        col_slots_t right_slots;

        if (k + 1 < MAX_COLS)
        begin : g_right
            assign right_slots = slot_chain[k+1];
        end
        else
        begin : g_edge
            assign right_slots = '0;
        end

        glmrs_cell #(
            .IDX      (k),
            .MAX_COLS (MAX_COLS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .wr_en       (accept),
            .wr_col      (wr_col),
            .wr_slot     (slot_reg),
            .wr_height   (height),
            .right_slots (right_slots),
            .slots       (slot_chain[k]),
            .tok_in      (tok_chain[k]),
            .carry_in    (carry_chain[k]),
            .cols_in     (cols_chain[k]),
            .tok_out     (tok_chain[k+1]),
            .carry_out   (carry_chain[k+1]),
            .cols_out    (cols_chain[k+1])
        );
    end

    // Grid accumulation of the row sums leaving the chain; saturate at the field limits
    always_comb
    begin
        risk_sum  = (RISK_W + 1)'(acc_risk_reg) + (RISK_W + 1)'(carry_chain[MAX_COLS].risk);
        count_sum = (COUNT_W + 1)'(acc_count_reg)
                  + (COUNT_W + 1)'(carry_chain[MAX_COLS].count);
        risk_sat  = risk_sum[RISK_W] ? RISK_MAX : risk_sum[RISK_W-1:0];
        count_sat = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];

        res_push       = tok_chain[MAX_COLS].valid && tok_chain[MAX_COLS].grid_end;
        res_data.risk  = risk_sat;
        res_data.count = count_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_risk_reg  <= '0;
            acc_count_reg <= '0;
        end
        else if (tok_chain[MAX_COLS].valid)
        begin
            if (tok_chain[MAX_COLS].grid_end)
            begin
                acc_risk_reg  <= '0;
                acc_count_reg <= '0;
            end
            else
            begin
                acc_risk_reg  <= risk_sat;
                acc_count_reg <= count_sat;
            end
        end
    end

    // Results in flight or queued; hold the input when the queue could fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_reg + OCW'(grid_in) - OCW'(grid_out);
    end

    glmrs_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {OUT_PAD_W'(0), out_res.count, out_res.risk};

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(occ_reg) <= FIFO_DEPTH)
        else $error("pending result count above queue depth");

    a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (occ_reg != '0))
        else $error("result offered with no grid pending");

    a_grid_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (grid_in && !grid_out) |=> (occ_reg == $past(occ_reg) + OCW'(1)))
        else $error("grid end not counted as pending result");

    a_push_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (occ_reg != '0))
        else $error("result produced with no grid pending");

endmodule
